// File: src/iisr_pkg.sv
`default_nettype none
package iisr_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxHeight);
  localparam int CfgW   = 11;
  localparam int PixW   = 8;
  localparam int AreaW  = 28;
  localparam int SqMemW = 37;
  localparam int SqW    = 36;
  localparam int RotW   = 28;
  localparam int AccW   = 18;
  localparam int RunSqW = 26;

  // register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // control of the word waiting for its read data
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            row_nz;
    logic            row_ge2;
    logic            first_col;
    logic            last_col;
    logic            last;
    logic            epoch;
    logic [ColW-1:0] lslot;
    logic [ColW-1:0] rslot;
    logic [PixW-1:0] pix;
  } s1_t;

  function automatic logic [CfgW-1:0] clamp(input logic [CfgW-1:0] v,
                                            input logic [CfgW-1:0] lo,
                                            input logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/integral_image_sat_sq_rot.sv
// Streaming integral image: for each 8-bit pixel in raster order gives the
// summed-area value, the squared summed-area value and the 45-degree rotated
// sum, one word per clock. A pixel is read out of the line buffers in the
// cycle it is taken and written back when its result moves to the output
// register, so the block sustains one pixel per cycle; besides the clearing
// pass, the only stall is backpressure on the output. After reset and after
// every register write the two diagonal accumulator memories are cleared,
// one entry a cycle, all 1024 entries; no pixel is taken meanwhile. Writing
// a register restarts the frame; frame_last (tlast) marks its last pixel.
`default_nettype none
module integral_image_sat_sq_rot (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [iisr_pkg::CfgW-1:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // pixel[7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // area_sum[27:0], square_sum[63:28], rotated_sum[91:64]
  output logic             m_tlast    // frame_last
);
  import iisr_pkg::*;

  localparam logic [CfgW-1:0] MinW = CfgW'(3);
  localparam logic [CfgW-1:0] MaxW = CfgW'(MaxWidth);
  localparam logic [CfgW-1:0] MinH = CfgW'(1);
  localparam logic [CfgW-1:0] MaxH = CfgW'(MaxHeight);

  // configuration
  logic [CfgW-1:0] img_w, img_h;
  logic [ColW:0]   clr_cnt;
  logic            clearing;

  // input-side counters
  logic [ColW-1:0] col, ymod, lslot, rslot;
  logic [RowW-1:0] row;
  logic            epoch;

  // pipeline
  s1_t             s1;
  logic            s1_valid, s1_adv, accept;

  // memories
  logic [AreaW-1:0]  area_mem [MaxWidth];
  logic [SqMemW-1:0] sq_mem   [MaxWidth];
  logic [RotW-1:0]   m1_mem   [MaxWidth];
  logic [RotW-1:0]   m2_mem   [MaxWidth];
  logic [PixW-1:0]   pix_mem  [MaxWidth];
  logic [AccW:0]     lacc_mem [MaxWidth];
  logic [AccW:0]     racc_mem [MaxWidth];

  logic [AreaW-1:0]  rd_area;
  logic [SqMemW-1:0] rd_sq;
  logic [RotW-1:0]   rd_m1a, rd_m1b, rd_m2;
  logic [PixW-1:0]   rd_pix;
  logic [AccW:0]     rd_lacc, rd_racc;

  // running state of the compute stage
  logic [AccW-1:0]   run_sum;
  logic [RunSqW-1:0] run_sq;
  logic [RotW-1:0]   left_rot, right_rot, rot_hold;

  logic [ColW-1:0] w_m1;
  logic [RowW:0]   row_p1;
  logic            last_col0, last0;

  assign w_m1      = ColW'(img_w - CfgW'(1));
  assign last_col0 = (col == w_m1);
  assign row_p1    = {1'b0, row} + 1'b1;
  assign last0     = last_col0 && ({1'b0, row_p1} >= {1'b0, img_h});

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // configuration registers and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w    <= CfgW'(640);
      img_h    <= CfgW'(480);
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegWidth) img_w <= clamp(cfg_data, MinW, MaxW);
      if (cfg_index == RegHeight) img_h <= clamp(cfg_data, MinH, MaxH);
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (ColW+1)'(MaxWidth - 1)) clearing <= 1'b0;
    end
  end

  // advance the raster counters and diagonal slots
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col   <= '0;
      row   <= '0;
      ymod  <= '0;
      lslot <= '0;
      rslot <= ColW'((rst ? CfgW'(639) :
                      (cfg_index == RegWidth) ? clamp(cfg_data, MinW, MaxW) - CfgW'(1) :
                      img_w - CfgW'(1)));
      epoch <= 1'b0;
    end else if (accept) begin
      if (last0) begin
        col   <= '0;
        row   <= '0;
        ymod  <= '0;
        lslot <= '0;
        rslot <= w_m1;
        epoch <= ~epoch;
      end else if (last_col0) begin
        col   <= '0;
        row   <= row + 1'b1;
        ymod  <= (ymod == w_m1) ? '0 : ymod + 1'b1;
        lslot <= (ymod == w_m1) ? '0 : ymod + 1'b1;
        rslot <= ymod;
      end else begin
        col   <= col + 1'b1;
        lslot <= (lslot == w_m1) ? '0 : lslot + 1'b1;
        rslot <= (rslot == '0) ? w_m1 : rslot - 1'b1;
      end
    end
  end

  // hold the word whose read data is in flight
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.col       <= col;
      s1.row_nz    <= (row != '0);
      s1.row_ge2   <= (row > RowW'(1));
      s1.first_col <= (col == '0);
      s1.last_col  <= last_col0;
      s1.last      <= last0;
      s1.epoch     <= epoch;
      s1.lslot     <= lslot;
      s1.rslot     <= rslot;
      s1.pix       <= s_tdata;
    end
  end

  // compute the three sums
  logic [AccW-1:0]   run_sum_next, lacc, racc, lacc_wr, racc_wr;
  logic [RunSqW-1:0] run_sq_next;
  logic [AreaW-1:0]  area;
  logic [SqMemW-1:0] sq;
  logic [RotW-1:0]   left_rot_next, right_rot_next, rot;
  logic [15:0]       pix_sq;

  always_comb begin
    pix_sq       = 16'(s1.pix) * 16'(s1.pix);
    run_sum_next = (s1.first_col ? '0 : run_sum) + AccW'(s1.pix);
    run_sq_next  = (s1.first_col ? '0 : run_sq) + RunSqW'(pix_sq);
    area = AreaW'(run_sum_next) + (s1.row_nz ? rd_area : '0);
    sq   = SqMemW'(run_sq_next) + (s1.row_nz ? rd_sq : '0);

    lacc = (rd_lacc[AccW] == s1.epoch) ? rd_lacc[AccW-1:0] : '0;
    racc = (rd_racc[AccW] == s1.epoch) ? rd_racc[AccW-1:0] : '0;
    left_rot_next  = left_rot;
    right_rot_next = right_rot;
    if (s1.first_col) begin
      left_rot_next = left_rot + RotW'(lacc) + RotW'(s1.pix);
      lacc_wr = '0;
    end else begin
      lacc_wr = lacc + AccW'(s1.pix);
    end
    if (s1.last_col) begin
      right_rot_next = right_rot + RotW'(racc) + RotW'(s1.pix);
      racc_wr = '0;
    end else begin
      racc_wr = racc + AccW'(s1.pix);
    end

    if (s1.first_col) begin
      rot = left_rot_next;
    end else if (s1.last_col) begin
      rot = right_rot_next;
    end else if (!s1.row_nz) begin
      rot = RotW'(s1.pix);
    end else begin
      rot = rot_hold + rd_m1b + RotW'(s1.pix) + RotW'(rd_pix)
          - (s1.row_ge2 ? rd_m2 : '0);
    end
  end

  // update running state, clear the rotated-sum state at frame end
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      run_sum   <= '0;
      run_sq    <= '0;
      left_rot  <= '0;
      right_rot <= '0;
      rot_hold  <= '0;
    end else if (s1_adv) begin
      run_sum <= run_sum_next;
      run_sq  <= run_sq_next;
      if (s1.last) begin
        left_rot  <= '0;
        right_rot <= '0;
        rot_hold  <= '0;
      end else begin
        left_rot  <= left_rot_next;
        right_rot <= right_rot_next;
        rot_hold  <= rd_m1a;
      end
    end
  end

  // line buffers: read on accept, write back on advance
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_area <= area_mem[col];
      rd_sq   <= sq_mem[col];
      rd_m1a  <= m1_mem[col];
      rd_m1b  <= m1_mem[col + 1'b1];
      rd_m2   <= m2_mem[col];
      rd_pix  <= pix_mem[col];
    end
    if (s1_adv) begin
      area_mem[s1.col] <= area;
      sq_mem[s1.col]   <= sq;
      m1_mem[s1.col]   <= rot;
      m2_mem[s1.col]   <= rd_m1a;
      pix_mem[s1.col]  <= s1.pix;
    end
  end

  // diagonal accumulators, tagged with the frame epoch
  always_ff @(posedge clk) begin
    if (accept) begin
      // forward a write-back to the same slot in this cycle
      if (s1_adv && (s1.lslot == lslot)) rd_lacc <= {s1.epoch, lacc_wr};
      else rd_lacc <= lacc_mem[lslot];
      if (s1_adv && (s1.rslot == rslot)) rd_racc <= {s1.epoch, racc_wr};
      else rd_racc <= racc_mem[rslot];
    end
    if (clearing) begin
      lacc_mem[clr_cnt[ColW-1:0]] <= '0;
      racc_mem[clr_cnt[ColW-1:0]] <= '0;
    end else if (s1_adv) begin
      lacc_mem[s1.lslot] <= {s1.epoch, lacc_wr};
      racc_mem[s1.rslot] <= {s1.epoch, racc_wr};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {4'b0, rot, sq[SqW-1:0], area};
      m_tlast <= s1.last;
    end
  end

  // no pixel is taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst) clearing |-> !accept)
    else $error("pixel accepted during clearing pass");

  // a stalled word keeps its column
  assert property (@(posedge clk) disable iff (rst || cfg_we)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1.col)))
    else $error("stalled word lost");

  // a word leaving the compute stage lands in the output register
  assert property (@(posedge clk) disable iff (rst || cfg_we)
    s1_adv |=> m_tvalid)
    else $error("result dropped");

endmodule
`default_nettype wire
